@@ rtl/dump_block_parser_top_macros.svh @@
`ifndef DUMP_BLOCK_PARSER_TOP_MACROS_SVH
`define DUMP_BLOCK_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define DBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dbp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dbp_pkg;

    // result codes
    typedef enum logic [2:0] {
        KIND_DATA       = 3'd0,
        KIND_SUM_OK     = 3'd1,
        KIND_SUM_BAD    = 3'd2,
        KIND_INCOMPLETE = 3'd3,
        KIND_SIZE_OVER  = 3'd4,
        KIND_DUMP_END   = 3'd5
    } kind_t;

    // start and size words ahead of the data
    localparam int HEADER_WORDS = 2;
    // start, size and checksum words around the data
    localparam int OVERHEAD_WORDS = 3;
    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // one queue entry: the results caused by one byte
    typedef struct packed {
        kind_t       kind;
        logic [15:0] word_value;
        logic [5:0]  word_index;
        logic [15:0] block_start;
        logic [15:0] computed_sum;
        logic        has_end;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } entry_slot_t;

endpackage

`default_nettype wire

@@ rtl/dbp_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_stream;

    modport source (output valid, output byte_in, output end_of_stream, input ready);
    modport sink (input valid, input byte_in, input end_of_stream, output ready);
endinterface

`default_nettype wire

@@ rtl/dbp_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dbp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] word_value;
    logic [5:0]  word_index;
    logic [15:0] block_start;
    logic [15:0] computed_sum;
    logic        last;

    modport source (output valid, output kind, output word_value, output word_index,
                    output block_start, output computed_sum, output last, input ready);
    modport sink (input valid, input kind, input word_value, input word_index,
                  input block_start, input computed_sum, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/dbp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dbp_front
    import dbp_pkg::*;
#(
    parameter int DATA_WORDS = 64
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dbp_in_if.sink      byte_ch,
    input  wire logic   queue_full,
    output entry_slot_t push
);

    localparam int CW = $clog2(DATA_WORDS + OVERHEAD_WORDS + 1);

    logic          have_high_reg, have_high_next;
    logic [7:0]    high_reg, high_next;
    logic [CW-1:0] words_reg, words_next;
    logic [15:0]   start_reg, start_next;
    logic [15:0]   size_reg, size_next;
    logic [15:0]   sum_reg, sum_next;
    logic [15:0]   last_word_reg, last_word_next;
    logic          stopped_reg, stopped_next;

    logic          accept;
    logic          eos;
    logic [15:0]   w;
    logic [CW-1:0] i_plus;
    logic          block_full;
    logic          closing;
    logic [CW-1:0] nw;
    logic [15:0]   chk;
    logic [15:0]   nd16;
    logic [15:0]   idx16;
    logic [15:0]   sum_plus;

    assign byte_ch.ready = !queue_full;
    assign accept        = byte_ch.valid && byte_ch.ready;
    assign eos           = byte_ch.end_of_stream;

    // word assembly and block position
    assign w          = {high_reg, byte_ch.byte_in};
    assign i_plus     = words_reg + 1'b1;
    assign block_full = (i_plus >= CW'(DATA_WORDS + OVERHEAD_WORDS));
    assign closing    = have_high_reg ? (eos || block_full) : eos;
    assign nw         = have_high_reg ? i_plus : words_reg;
    assign chk        = have_high_reg ? w : last_word_reg;
    assign nd16       = 16'(nw) - 16'(OVERHEAD_WORDS);
    assign idx16      = 16'(words_reg) - 16'(HEADER_WORDS);
    assign sum_plus   = sum_reg + w;

    // parse step and result classification
    always_comb
    begin
        have_high_next = have_high_reg;
        high_next      = high_reg;
        words_next     = words_reg;
        start_next     = start_reg;
        size_next      = size_reg;
        sum_next       = sum_reg;
        last_word_next = last_word_reg;
        stopped_next   = stopped_reg;

        push                    = '0;
        push.entry.kind         = KIND_DATA;
        push.entry.block_start  = start_reg;
        push.entry.computed_sum = sum_reg;

        if (accept && !stopped_reg)
        begin
            if (!have_high_reg)
            begin
                high_next      = byte_ch.byte_in;
                have_high_next = 1'b1;
            end
            else
            begin
                have_high_next = 1'b0;
                if (closing)
                begin
                    words_next = '0;
                end
                else
                begin
                    if (words_reg == CW'(0))
                    begin
                        start_next = w;
                        sum_next   = w;
                    end
                    else if (words_reg == CW'(1))
                    begin
                        size_next = w;
                        sum_next  = sum_plus;
                    end
                    else if (idx16 < size_reg)
                    begin
                        sum_next                = sum_plus;
                        push.valid              = 1'b1;
                        push.entry.kind         = KIND_DATA;
                        push.entry.word_value   = w;
                        push.entry.word_index   = idx16[5:0];
                        push.entry.computed_sum = sum_plus;
                    end
                    last_word_next = w;
                    words_next     = i_plus;
                end
            end

            // block close
            if (closing)
            begin
                push.valid = 1'b1;
                if (nw < CW'(OVERHEAD_WORDS))
                begin
                    push.entry.kind = KIND_INCOMPLETE;
                    stopped_next    = 1'b1;
                end
                else if (size_reg > nd16)
                begin
                    push.entry.kind = KIND_SIZE_OVER;
                    stopped_next    = 1'b1;
                end
                else if (nw == CW'(OVERHEAD_WORDS))
                begin
                    push.entry.kind = KIND_DUMP_END;
                    stopped_next    = 1'b1;
                end
                else
                begin
                    push.entry.kind       = (sum_reg == chk) ? KIND_SUM_OK : KIND_SUM_BAD;
                    push.entry.word_value = chk;
                    if (eos || (size_reg < 16'(DATA_WORDS)))
                    begin
                        push.entry.has_end = 1'b1;
                        stopped_next       = 1'b1;
                    end
                end
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_high_reg <= 1'b0;
            high_reg      <= '0;
            words_reg     <= '0;
            start_reg     <= '0;
            size_reg      <= '0;
            sum_reg       <= '0;
            last_word_reg <= '0;
            stopped_reg   <= 1'b0;
        end
        else
        begin
            have_high_reg <= have_high_next;
            high_reg      <= high_next;
            words_reg     <= words_next;
            start_reg     <= start_next;
            size_reg      <= size_next;
            sum_reg       <= sum_next;
            last_word_reg <= last_word_next;
            stopped_reg   <= stopped_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dbp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dbp_queue
    import dbp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire entry_slot_t  push,
    input  wire logic         pop,
    output logic              full,
    output entry_slot_t       head
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    entry_t        slots_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == NW'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = slots_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dbp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dbp_back
    import dbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire entry_slot_t head,
    output logic             pop,
    dbp_out_if.source        result_ch
);

    // high while the trailing dump end of the head entry is on the port
    logic end_phase_reg, end_phase_next;
    logic xfer;

    assign result_ch.valid = head.valid;
    assign xfer            = result_ch.valid && result_ch.ready;
    assign pop             = xfer && (end_phase_reg || !head.entry.has_end);

    // result fields for the current phase
    always_comb
    begin
        result_ch.block_start  = head.entry.block_start;
        result_ch.computed_sum = head.entry.computed_sum;
        if (end_phase_reg)
        begin
            result_ch.kind       = KIND_DUMP_END;
            result_ch.word_value = '0;
            result_ch.word_index = '0;
            result_ch.last       = 1'b1;
        end
        else
        begin
            result_ch.kind       = head.entry.kind;
            result_ch.word_value = head.entry.word_value;
            result_ch.word_index = head.entry.word_index;
            result_ch.last       = !head.entry.has_end;
        end
    end

    // phase advance on each transfer
    always_comb
    begin
        end_phase_next = end_phase_reg;
        if (xfer)
        begin
            end_phase_next = !end_phase_reg && head.entry.has_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_phase_reg <= 1'b0;
        end
        else
        begin
            end_phase_reg <= end_phase_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dump_block_parser_top.sv @@
// channel     dir  payload
// byte_ch     in   byte_in[7:0], end_of_stream
// result_ch   out  kind[2:0], word_value[15:0], word_index[5:0],
//                  block_start[15:0], computed_sum[15:0], last
//
// One byte is taken every cycle while the four-entry result queue has room.
// A byte leaves at most one queue entry; an entry goes out as one result, or as
// two when a checksum result is followed by the dump end result.
// Results appear on result_ch at the earliest in the cycle after their byte.
// rst_n clears parser state and the queue asynchronously; no clearing pass.
// A stall on result_ch fills the queue, then drops byte_ch.ready.
`timescale 1ns / 1ps
`default_nettype none

`include "dump_block_parser_top_macros.svh"

module dump_block_parser_top
    import dbp_pkg::*;
#(
    parameter int DATA_WORDS = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    dbp_in_if.sink    byte_ch,
    dbp_out_if.source result_ch
);

    entry_slot_t push;
    entry_slot_t head;
    logic        queue_full;
    logic        pop;

    // byte parsing and classification
    dbp_front #(
        .DATA_WORDS (DATA_WORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .queue_full (queue_full),
        .push       (push)
    );

    // decoupling queue
    dbp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .head  (head)
    );

    // result sequencing
    dbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .result_ch (result_ch)
    );

    // checks
    `DBP_ASSERT_NOW(a_no_overflow, push.valid, !queue_full, "entry pushed into a full queue")
    `DBP_ASSERT_NOW(a_end_is_last, result_ch.valid && (result_ch.kind == KIND_DUMP_END),
        result_ch.last, "dump end result not marked last")
    `DBP_ASSERT_NEXT(a_end_follows, result_ch.valid && result_ch.ready && !result_ch.last,
        result_ch.valid && (result_ch.kind == KIND_DUMP_END),
        "non-final result not followed by dump end")

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import dbp_pkg::*;

    localparam int DATA_WORDS = 64;
    localparam int FULL_BLOCK = DATA_WORDS + OVERHEAD_WORDS;
    localparam int OPENING_ROWS = 18;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 20;

    // one result as it should appear on result_ch
    typedef struct packed {
        kind_t       kind;
        logic [15:0] value;
        logic [5:0]  index;
        logic [15:0] start;
        logic [15:0] sum;
        logic        last;
    } parse_result_t;

    // one row of the opening byte table
    typedef struct packed {
        logic [7:0]    b;
        logic          typed;
        parse_result_t want;
    } stim_row_t;

    typedef enum {BLK_GO_ON, BLK_CLEAN, BLK_ERROR} block_close_t;

    typedef enum {RX_STEADY, RX_LIGHT, RX_HALF, RX_HEAVY} stall_mode_t;

    typedef enum {
        END_FULL_SHORT_SIZE,
        END_FULL_SIZE_OVER,
        END_FULL_EOS,
        END_SHORT_CLEAN,
        END_SHORT_SIZE_OVER,
        END_INCOMPLETE,
        END_ODD_BYTE
    } dump_ending_t;

    logic clk;
    logic rst_n;

    dbp_in_if  byte_ch ();
    dbp_out_if result_ch ();

    dump_block_parser_top #(
        .DATA_WORDS (DATA_WORDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    // parser state as the block should hold it
    logic          have_hi   = 1'b0;
    logic [7:0]    hi_byte   = '0;
    int unsigned   words_seen = 0;
    logic [15:0]   start_w   = '0;
    logic [15:0]   size_w    = '0;
    logic [15:0]   sum_w     = '0;
    logic [15:0]   last_w    = '0;
    logic          stopped   = 1'b0;

    parse_result_t step_out[$];
    parse_result_t expected_results[$];
    stim_row_t     opening [OPENING_ROWS];

    int mismatch_count = 0;
    int burst_left = 0;
    int cycle_count = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic void note_result(kind_t k, logic [15:0] v, logic [5:0] idx);
        parse_result_t r;
        r.kind  = k;
        r.value = v;
        r.index = idx;
        r.start = start_w;
        r.sum   = sum_w;
        r.last  = 1'b0;
        step_out.push_back(r);
    endfunction

    // closes a block of nw words whose checksum word is chk
    function automatic block_close_t close_block(int unsigned nw, logic [15:0] chk);
        int unsigned nd;
        if (nw < OVERHEAD_WORDS)
        begin
            note_result(KIND_INCOMPLETE, '0, '0);
            return BLK_ERROR;
        end
        nd = nw - OVERHEAD_WORDS;
        if (size_w > nd)
        begin
            note_result(KIND_SIZE_OVER, '0, '0);
            return BLK_ERROR;
        end
        // three-word block: no check at all
        if (nd == 0)
            return BLK_CLEAN;
        note_result((sum_w == chk) ? KIND_SUM_OK : KIND_SUM_BAD, chk, '0);
        if (size_w < DATA_WORDS)
            return BLK_CLEAN;
        return BLK_GO_ON;
    endfunction

    // advances the parser state by one byte, results land in step_out
    function automatic void parse_step(logic [7:0] b, logic eos);
        logic [15:0]   w;
        int unsigned   i;
        block_close_t  res;
        logic          closed;
        parse_result_t r;
        step_out.delete();
        res = BLK_GO_ON;
        closed = 1'b0;
        if (stopped)
            return;
        if (!have_hi)
        begin
            hi_byte = b;
            have_hi = 1'b1;
            // trailing odd byte: the last whole word is the checksum
            if (eos)
            begin
                res = close_block(words_seen, last_w);
                closed = 1'b1;
            end
        end
        else
        begin
            w = {hi_byte, b};
            i = words_seen;
            have_hi = 1'b0;
            if (eos || i + 1 >= FULL_BLOCK)
            begin
                res = close_block(i + 1, w);
                closed = 1'b1;
                words_seen = 0;
            end
            else
            begin
                if (i == 0)
                begin
                    start_w = w;
                    sum_w = w;
                end
                else if (i == 1)
                begin
                    size_w = w;
                    sum_w = sum_w + w;
                end
                else if (i - HEADER_WORDS < size_w)
                begin
                    sum_w = sum_w + w;
                    note_result(KIND_DATA, w, 6'(i - HEADER_WORDS));
                end
                last_w = w;
                words_seen = i + 1;
            end
        end
        if (closed)
        begin
            if (res == BLK_ERROR)
                stopped = 1'b1;
            else if (res == BLK_CLEAN || eos)
            begin
                note_result(KIND_DUMP_END, '0, '0);
                stopped = 1'b1;
            end
        end
        if (step_out.size() > 0)
        begin
            r = step_out.pop_back();
            r.last = 1'b1;
            step_out.push_back(r);
        end
    endfunction

    // drives one byte in bursts, called and returning at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed,
                             input parse_result_t typed_res);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                     : $urandom_range(1, 24);
            if (gap > 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        byte_ch.valid         <= 1'b1;
        byte_ch.byte_in       <= b;
        byte_ch.end_of_stream <= eos;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        // transfer taken: work out what it causes
        parse_step(b, eos);
        if (typed)
            expected_results.push_back(typed_res);
        else
            foreach (step_out[k])
                expected_results.push_back(step_out[k]);
        @(negedge clk);
    endtask

    task automatic send_word(input logic [15:0] w, input logic eos);
        send_byte(w[15:8], 1'b0, 1'b0, '0);
        send_byte(w[7:0], eos, 1'b0, '0);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // data words then the checksum word, right or corrupted
    task automatic send_block_tail(input int n_data, input logic eos);
        logic [15:0] chk;
        repeat (n_data) send_word(rand_word(), 1'b0);
        chk = sum_w;
        if ($urandom_range(0, 3) == 0)
            chk = chk ^ 16'($urandom_range(1, 65535));
        send_word(chk, eos);
    endtask

    task automatic send_header(input logic [15:0] size);
        send_word(rand_word(), 1'b0);
        send_word(size, 1'b0);
    endtask

    function automatic stim_row_t plain_row(logic [7:0] b);
        stim_row_t r;
        r = '0;
        r.b = b;
        return r;
    endfunction

    // data word of the opening block, whose start word is all ones
    function automatic stim_row_t typed_row(logic [7:0] b, logic [15:0] v, logic [5:0] idx,
                                            logic [15:0] sum);
        stim_row_t r;
        r.b          = b;
        r.typed      = 1'b1;
        r.want.kind  = KIND_DATA;
        r.want.value = v;
        r.want.index = idx;
        r.want.start = 16'hFFFF;
        r.want.sum   = sum;
        r.want.last  = 1'b1;
        return r;
    endfunction

    // receiver stalls
    initial
    begin : result_stall
        stall_mode_t mode;
        int left;
        result_ch.ready = 1'b0;
        mode = RX_STEADY;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                left = $urandom_range(16, 160);
            end
            left--;
            case (mode)
                RX_STEADY: result_ch.ready <= 1'b1;
                RX_LIGHT:  result_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_HALF:   result_ch.ready <= 1'($urandom_range(0, 1));
                default:   result_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        parse_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: kind %0d word_value %h",
                       result_ch.kind, result_ch.word_value);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_ch.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, result_ch.kind);
                    mismatch_count++;
                end
                if (result_ch.word_value !== want.value)
                begin
                    $error("word_value: expected %h, got %h", want.value, result_ch.word_value);
                    mismatch_count++;
                end
                if (result_ch.word_index !== want.index)
                begin
                    $error("word_index: expected %0d, got %0d", want.index, result_ch.word_index);
                    mismatch_count++;
                end
                if (result_ch.block_start !== want.start)
                begin
                    $error("block_start: expected %h, got %h", want.start, result_ch.block_start);
                    mismatch_count++;
                end
                if (result_ch.computed_sum !== want.sum)
                begin
                    $error("computed_sum: expected %h, got %h", want.sum, result_ch.computed_sum);
                    mismatch_count++;
                end
                if (result_ch.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result_ch.last);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        dump_ending_t ending;
        int pick;
        int nd;
        logic [15:0] size;
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.byte_in = '0;
        byte_ch.end_of_stream = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // opening block: all-ones start, full size, extreme data words
        opening[0]  = plain_row(8'hFF);
        opening[1]  = plain_row(8'hFF);
        opening[2]  = plain_row(8'h00);
        opening[3]  = plain_row(8'h40);
        opening[4]  = plain_row(8'h00);
        opening[5]  = typed_row(8'h00, 16'h0000, 6'd0, 16'h003F);
        opening[6]  = plain_row(8'hFF);
        opening[7]  = typed_row(8'hFF, 16'hFFFF, 6'd1, 16'h003E);
        opening[8]  = plain_row(8'h80);
        opening[9]  = typed_row(8'h00, 16'h8000, 6'd2, 16'h803E);
        opening[10] = plain_row(8'h7F);
        opening[11] = typed_row(8'hFF, 16'h7FFF, 6'd3, 16'h003D);
        opening[12] = plain_row(8'hA5);
        opening[13] = plain_row(8'h5A);
        opening[14] = plain_row(8'h01);
        opening[15] = plain_row(8'h23);
        opening[16] = plain_row(8'hC3);
        opening[17] = plain_row(8'h3C);
        foreach (opening[r])
            send_byte(opening[r].b, 1'b0, opening[r].typed, opening[r].want);

        // finish the opening block
        send_block_tail(DATA_WORDS - (words_seen - HEADER_WORDS), 1'b0);

        // hold off until the result side has drained
        byte_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);

        // full blocks that keep the dump going
        repeat (8)
        begin
            send_header(16'(DATA_WORDS));
            send_block_tail(DATA_WORDS, 1'b0);
        end

        // one way for the dump to end
        pick = $urandom_range(0, 7);
        ending = (pick > 6) ? END_SHORT_CLEAN : dump_ending_t'(pick);
        case (ending)
            END_FULL_SHORT_SIZE:
            begin
                send_header(16'($urandom_range(0, DATA_WORDS - 1)));
                send_block_tail(DATA_WORDS, 1'b0);
            end
            END_FULL_SIZE_OVER:
            begin
                size = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                   : 16'($urandom_range(DATA_WORDS + 1, 65535));
                send_header(size);
                send_block_tail(DATA_WORDS, 1'b0);
            end
            END_FULL_EOS:
            begin
                send_header(16'(DATA_WORDS));
                send_block_tail(DATA_WORDS, 1'b1);
            end
            END_SHORT_CLEAN:
            begin
                nd = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, DATA_WORDS - 1);
                send_header(16'($urandom_range(0, nd)));
                send_block_tail(nd, 1'b1);
            end
            END_SHORT_SIZE_OVER:
            begin
                nd = $urandom_range(0, DATA_WORDS - 1);
                size = ($urandom_range(0, 1) == 0) ? 16'(nd + 1)
                                                   : 16'($urandom_range(nd + 1, 65535));
                send_header(size);
                send_block_tail(nd, 1'b1);
            end
            END_INCOMPLETE:
            begin
                // fewer than three words, with or without an odd byte
                repeat ($urandom_range(0, 4))
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
                send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
            end
            default:
            begin
                // short block, then an odd byte that gets dropped
                nd = $urandom_range(0, DATA_WORDS - 1);
                send_header(16'($urandom_range(0, nd)));
                send_block_tail(nd, 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
            end
        endcase

        // bytes after the end are ignored
        repeat ($urandom_range(2, 10))
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);

        byte_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
